>>> hw/rtl/csvsn_pkg.sv
// ----------------------------------------------------------------------------
// csvsn_pkg
// Types and constants shared by the CSV content sniffer modules.
// ----------------------------------------------------------------------------
package csvsn_pkg;

   localparam int CountWidth = 16;
   localparam int LinesWidth = 7;

   localparam logic [LinesWidth-1:0] MaxLines      = 7'd10;
   localparam logic [CountWidth-1:0] ScanLimitReset = 16'd512;
   localparam logic [CountWidth-1:0] MinTotalBytes = 16'd3;
   localparam logic [CountWidth-1:0] MinCommas     = 16'd2;
   localparam logic [LinesWidth-1:0] MinLines      = 7'd2;
   localparam logic [LinesWidth-1:0] MatchMax      = 7'd127;
   localparam logic [7:0]            ByteComma     = 8'h2C;
   localparam logic [7:0]            ByteNewline   = 8'h0A;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } byte_item_type;

   typedef struct packed {
      logic                  is_csv;
      logic [LinesWidth-1:0] lines_scanned;
      logic [CountWidth-1:0] commas_scanned;
   } verdict_type;

   typedef struct packed {
      logic [LinesWidth-1:0] lines_ended;
      logic [LinesWidth-1:0] matching_lines;
   } scan_status_type;

   function automatic logic [CountWidth-1:0] sat_inc16(input logic [CountWidth-1:0] v);
      logic [CountWidth-1:0] r;
      r = (v != {CountWidth{1'b1}}) ? v + 1'b1 : v;
      return r;
   endfunction

endpackage

>>> hw/rtl/csvsn_if.sv
// ----------------------------------------------------------------------------
// csvsn channel interfaces
// Valid/ready channels for byte items, verdict items and the scan limit write.
// ----------------------------------------------------------------------------
interface csvsn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface csvsn_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           is_csv;
   logic [csvsn_pkg::LinesWidth-1:0] lines_scanned;
   logic [csvsn_pkg::CountWidth-1:0] commas_scanned;

   modport source (output valid, output is_csv, output lines_scanned,
                   output commas_scanned, input ready);
   modport sink   (input valid, input is_csv, input lines_scanned,
                   input commas_scanned, output ready);
endinterface

interface csvsn_csr_if;
   logic                           valid;
   logic                           ready;
   logic [csvsn_pkg::CountWidth-1:0] scan_limit;

   modport source (output valid, output scan_limit, input ready);
   modport sink   (input valid, input scan_limit, output ready);
endinterface

>>> hw/rtl/csvsn_in_stage.sv
// ----------------------------------------------------------------------------
// csvsn_in_stage
// Input register for byte items; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module csvsn_in_stage (
   input  logic                     clock,
   input  logic                     reset,
   csvsn_req_if.sink                req,
   input  logic                     take,
   output logic                     item_valid,
   output csvsn_pkg::byte_item_type item
);
   import csvsn_pkg::*;

   logic          valid_ff, valid_in;
   byte_item_type item_ff;
   logic          accept;

   assign req.ready = !valid_ff || take;
   assign accept    = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.data_byte <= req.data_byte;
         item_ff.last_byte <= req.last_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hw/rtl/csvsn_scan.sv
// ----------------------------------------------------------------------------
// csvsn_scan
// Scan counters, scan limit register and the verdict for the last byte.
// ----------------------------------------------------------------------------
module csvsn_scan (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  csvsn_pkg::byte_item_type   item,
   input  logic                       limit_we,
   input  logic [csvsn_pkg::CountWidth-1:0] limit_data,
   output csvsn_pkg::verdict_type     verdict,
   output csvsn_pkg::scan_status_type status
);
   import csvsn_pkg::*;

   logic [CountWidth-1:0] limit_ff;
   logic [CountWidth-1:0] total_ff, total_in;
   logic [CountWidth-1:0] scanned_ff, scanned_in;
   logic [CountWidth-1:0] comma_ff, comma_in;
   logic [LinesWidth-1:0] lines_ff, lines_in;
   logic [CountWidth-1:0] first_ff, first_in;
   logic [CountWidth-1:0] line_ff, line_in;
   logic [LinesWidth-1:0] match_ff, match_in;
   logic                  in_scan;
   logic [LinesWidth-1:0] half_lines;

   assign in_scan = (scanned_ff < limit_ff) && (lines_ff < MaxLines);

   always_comb begin
      total_in   = sat_inc16(total_ff);
      scanned_in = scanned_ff;
      comma_in   = comma_ff;
      lines_in   = lines_ff;
      first_in   = first_ff;
      line_in    = line_ff;
      match_in   = match_ff;
      if (in_scan) begin
         scanned_in = scanned_ff + 1'b1;
         if (item.data_byte == ByteComma) begin
            comma_in = sat_inc16(comma_ff);
            line_in  = sat_inc16(line_ff);
         end else if (item.data_byte == ByteNewline) begin
            if (lines_ff == '0) begin
               first_in = line_ff;
            end else if (line_ff == first_ff && match_ff < MatchMax) begin
               match_in = match_ff + 1'b1;
            end
            lines_in = lines_ff + 1'b1;
            line_in  = '0;
         end
      end
   end

   assign half_lines = (lines_in - 1'b1) >> 1;

   always_comb begin
      verdict.is_csv = (total_in >= MinTotalBytes) && (comma_in >= MinCommas) &&
                       (lines_in >= MinLines) && (match_in >= half_lines);
      verdict.lines_scanned  = lines_in;
      verdict.commas_scanned = comma_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ScanLimitReset;
      end else if (limit_we) begin
         limit_ff <= limit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last_byte)) begin
         total_ff   <= '0;
         scanned_ff <= '0;
         comma_ff   <= '0;
         lines_ff   <= '0;
         first_ff   <= '0;
         line_ff    <= '0;
         match_ff   <= '0;
      end else if (step) begin
         total_ff   <= total_in;
         scanned_ff <= scanned_in;
         comma_ff   <= comma_in;
         lines_ff   <= lines_in;
         first_ff   <= first_in;
         line_ff    <= line_in;
         match_ff   <= match_in;
      end
   end

   assign status.lines_ended    = lines_ff;
   assign status.matching_lines = match_ff;

endmodule

>>> hw/rtl/csvsn_rsp_stage.sv
// ----------------------------------------------------------------------------
// csvsn_rsp_stage
// Output register for verdict items.
// ----------------------------------------------------------------------------
module csvsn_rsp_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  csvsn_pkg::verdict_type verdict,
   output logic                   can_load,
   csvsn_rsp_if.source            rsp
);
   import csvsn_pkg::*;

   logic        valid_ff, valid_in;
   verdict_type verdict_ff;

   assign can_load = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff <= verdict;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.is_csv         = verdict_ff.is_csv;
   assign rsp.lines_scanned  = verdict_ff.lines_scanned;
   assign rsp.commas_scanned = verdict_ff.commas_scanned;

endmodule

>>> hw/rtl/csv_content_sniffer_core.sv
// ----------------------------------------------------------------------------
// csv_content_sniffer_core
// Scans a byte buffer and gives one CSV verdict on its last byte.
// ----------------------------------------------------------------------------
//  channel    dir  payload                                  transfer
//  req_chan   in   data_byte[7:0], last_byte                valid & ready
//  rsp_chan   out  is_csv, lines_scanned[6:0],              valid & ready
//                  commas_scanned[15:0]
//  csr_chan   in   scan_limit[15:0]                         valid & ready
//
//  One byte item per cycle unless a last byte waits on a full output register.
//  A byte is held in the input register and is counted as it leaves; the
//  verdict of a last byte enters the output register as it leaves. Synchronous
//  reset clears counters, sets scan_limit to 512. Only a last byte waits on a
//  full output register; other bytes pass. csr_chan is always ready.
// ----------------------------------------------------------------------------
module csv_content_sniffer_core (
   input  logic      clock,
   input  logic      reset,
   csvsn_req_if.sink   req_chan,
   csvsn_rsp_if.source rsp_chan,
   csvsn_csr_if.sink   csr_chan
);
   import csvsn_pkg::*;

   logic            item_valid;
   byte_item_type   item;
   logic            advance;
   logic            can_load;
   logic            load;
   verdict_type     verdict;
   scan_status_type status;

   assign csr_chan.ready = 1'b1;

   assign advance = item_valid && (!item.last_byte || can_load);
   assign load    = advance && item.last_byte;

   csvsn_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .take       (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   csvsn_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (item),
      .limit_we   (csr_chan.valid),
      .limit_data (csr_chan.scan_limit),
      .verdict    (verdict),
      .status     (status)
   );

   csvsn_rsp_stage u_rsp (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .verdict  (verdict),
      .can_load (can_load),
      .rsp      (rsp_chan)
   );

   a_lines_bounded: assert property (@(posedge clock) disable iff (reset)
      status.lines_ended <= MaxLines)
      else $error("line count above limit");

   a_match_below_lines: assert property (@(posedge clock) disable iff (reset)
      (status.matching_lines < status.lines_ended) || (status.matching_lines == '0))
      else $error("matching lines not below ended lines");

   a_last_gives_item: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_chan.valid)
      else $error("last byte gave no verdict");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      load |=> (status.lines_ended == '0 && status.matching_lines == '0))
      else $error("state not cleared after last byte");

endmodule

>>> sim/csv_content_sniffer_core_test.sv
// ----------------------------------------------------------------------------
// csv_content_sniffer_core_test
// Self-checking bench for the CSV sniffer. It drives byte buffers with random
// sender bursts and receiver stalls. A local scan tracker predicts each
// verdict as its last byte is taken, and the bench checks every verdict
// field by field. The scan limit is changed between buffers.
// ----------------------------------------------------------------------------
module csv_content_sniffer_core_test;
   import csvsn_pkg::*;

   localparam int unsigned CycleLimit = 1_000_000;
   localparam int unsigned RandomItems = 1100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csvsn_req_if req_bus ();
   csvsn_rsp_if rsp_bus ();
   csvsn_csr_if csr_bus ();

   csv_content_sniffer_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // scan tracker state
   logic [CountWidth-1:0] scan_cap;
   logic [CountWidth-1:0] byte_total;
   logic [CountWidth-1:0] scan_count;
   logic [CountWidth-1:0] seen_commas;
   logic [CountWidth-1:0] head_commas;
   logic [CountWidth-1:0] cur_commas;
   logic [LinesWidth-1:0] seen_lines;
   logic [LinesWidth-1:0] matched_lines;

   byte_item_type byte_backlog[$];
   verdict_type   verdicts_due[$];
   logic [7:0]    draft[$];

   int unsigned items_sent;
   int unsigned error_count;
   int unsigned cycle_count;

   logic req_fired;
   bit   sender_gaps;
   int   burst_left;
   int   gap_left;

   int unsigned rx_period;
   int unsigned rx_duty;
   int unsigned rx_phase;
   int unsigned rx_hold;

   always #4 clock = ~clock;

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", msg);
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         flag_error($sformatf("%s: expected %0d, got %0d", name, want, got));
   endtask

   task automatic track_byte(input byte_item_type it);
      verdict_type v;
      if (byte_total != '1) byte_total = byte_total + 1'b1;
      if (scan_count < scan_cap && seen_lines < MaxLines) begin
         scan_count = scan_count + 1'b1;
         if (it.data_byte == ByteComma) begin
            if (seen_commas != '1) seen_commas = seen_commas + 1'b1;
            if (cur_commas != '1) cur_commas = cur_commas + 1'b1;
         end else if (it.data_byte == ByteNewline) begin
            if (seen_lines == '0)
               head_commas = cur_commas;
            else if (cur_commas == head_commas && matched_lines < MatchMax)
               matched_lines = matched_lines + 1'b1;
            seen_lines = seen_lines + 1'b1;
            cur_commas = '0;
         end
      end
      if (it.last_byte) begin
         v.is_csv = byte_total >= MinTotalBytes && seen_commas >= MinCommas &&
                    seen_lines >= MinLines &&
                    int'(matched_lines) >= (int'(seen_lines) - 1) / 2;
         v.lines_scanned = seen_lines;
         v.commas_scanned = seen_commas;
         verdicts_due.push_back(v);
         byte_total = '0;
         scan_count = '0;
         seen_commas = '0;
         head_commas = '0;
         cur_commas = '0;
         seen_lines = '0;
         matched_lines = '0;
      end
   endtask

   // acceptance and prediction
   always @(posedge clock) begin
      req_fired <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready)
         track_byte(byte_item_type'{req_bus.data_byte, req_bus.last_byte});
   end

   // byte driver
   always @(negedge clock) begin
      if (req_fired) begin
         void'(byte_backlog.pop_front());
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = int'($urandom_range(1, 24));
            gap_left = sender_gaps ? int'($urandom_range(0, 5)) : 0;
         end
      end
      if (reset || gap_left > 0 || byte_backlog.size() == 0) begin
         if (gap_left > 0) gap_left--;
         req_bus.valid <= 1'b0;
      end else begin
         req_bus.valid <= 1'b1;
         req_bus.data_byte <= byte_backlog[0].data_byte;
         req_bus.last_byte <= byte_backlog[0].last_byte;
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (rx_hold == 0) begin
         rx_hold = $urandom_range(20, 80);
         if ($urandom_range(0, 3) == 0) begin
            rx_period = 1;
            rx_duty = 1;
         end else begin
            rx_period = $urandom_range(2, 8);
            rx_duty = $urandom_range(1, rx_period - 1);
         end
         rx_phase = 0;
      end
      rx_hold--;
      rsp_bus.ready <= rx_phase < rx_duty;
      rx_phase = (rx_phase + 1) % rx_period;
   end

   // verdict monitor
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (verdicts_due.size() == 0) begin
            flag_error($sformatf("verdict with none pending: csv %0b lines %0d commas %0d",
                                 rsp_bus.is_csv, rsp_bus.lines_scanned,
                                 rsp_bus.commas_scanned));
         end else begin
            want = verdicts_due.pop_front();
            check_field("is_csv", rsp_bus.is_csv, want.is_csv);
            check_field("lines_scanned", rsp_bus.lines_scanned, want.lines_scanned);
            check_field("commas_scanned", rsp_bus.commas_scanned, want.commas_scanned);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == ByteComma || b == ByteNewline);
      return b;
   endfunction

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
   endtask

   task automatic commit_draft();
      if (draft.size() == 0) draft.push_back(plain_byte());
      for (int i = 0; i < draft.size(); i++)
         byte_backlog.push_back(byte_item_type'{draft[i], i == draft.size() - 1});
      items_sent += draft.size();
      draft.delete();
   endtask

   task automatic wait_idle();
      while (byte_backlog.size() != 0 || verdicts_due.size() != 0) @(negedge clock);
   endtask

   task automatic set_scan_limit(input logic [CountWidth-1:0] v);
      wait_idle();
      repeat (4) @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.scan_limit <= v;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      scan_cap = v;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // lines with a common comma count, some lines off, occasional stray bytes
   task automatic build_table_buffer();
      int unsigned cols;
      int unsigned rows;
      int unsigned n;
      cols = $urandom_range(0, 4);
      rows = $urandom_range(0, 13);
      for (int r = 0; r < rows; r++) begin
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 5) : cols;
         for (int c = 0; c <= n; c++) begin
            repeat ($urandom_range(0, 2))
               draft.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : plain_byte());
            if (c < n) draft.push_back(ByteComma);
         end
         draft.push_back(ByteNewline);
      end
      if ($urandom_range(0, 1)) begin
         repeat ($urandom_range(1, 4))
            draft.push_back(($urandom_range(0, 2) == 0) ? ByteComma : plain_byte());
      end
   endtask

   task automatic build_noise_buffer(input int unsigned max_len);
      repeat ($urandom_range(1, max_len)) begin
         case ($urandom_range(0, 3))
            0: draft.push_back(ByteComma);
            1: draft.push_back(ByteNewline);
            default: draft.push_back(8'($urandom));
         endcase
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.scan_limit = '0;
      scan_cap = ScanLimitReset;
      byte_total = '0;
      scan_count = '0;
      seen_commas = '0;
      head_commas = '0;
      cur_commas = '0;
      seen_lines = '0;
      matched_lines = '0;
      req_fired = 1'b0;
      sender_gaps = 1'b1;
      burst_left = 1;
      gap_left = 0;
      rx_hold = 0;
      rx_period = 1;
      rx_duty = 1;
      rx_phase = 0;
      items_sent = 0;
      error_count = 0;
      cycle_count = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset scan limit
      draft.push_back(8'hFF);
      commit_draft();
      draft.push_back(8'h00);
      add_text(",");
      draft.push_back(8'hFF);
      add_text(",\n,,\n");
      commit_draft();
      repeat (11) draft.push_back(ByteNewline);
      add_text(",");
      commit_draft();

      set_scan_limit(16'd1);
      add_text(",\n,");
      commit_draft();

      set_scan_limit(16'd0);
      add_text(",,\n\n");
      commit_draft();

      // random buffers in groups, each group under its own scan limit
      items_sent = 0;
      while (items_sent < RandomItems) begin
         case ($urandom_range(0, 5))
            0: set_scan_limit(16'($urandom_range(1, 3)));
            1: set_scan_limit(16'($urandom_range(4, 40)));
            2: set_scan_limit(ScanLimitReset);
            3: set_scan_limit(16'hFFFF);
            4: set_scan_limit(16'($urandom_range(41, 600)));
            default: set_scan_limit(16'($urandom_range(1, 65535)));
         endcase
         sender_gaps = $urandom_range(0, 3) != 0;
         repeat (6) begin
            case ($urandom_range(0, 9))
               7: build_noise_buffer(30);
               8: build_noise_buffer(3);
               default: build_table_buffer();
            endcase
            commit_draft();
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/csvsn_pkg.sv
hw/rtl/csvsn_if.sv
hw/rtl/csvsn_in_stage.sv
hw/rtl/csvsn_scan.sv
hw/rtl/csvsn_rsp_stage.sv
hw/rtl/csv_content_sniffer_core.sv
sim/csv_content_sniffer_core_test.sv
